>>> design/rdra_pkg.sv
// ----------------------------------------------------------------------------
// Radiation dose-rate averager package
// Shared widths, types and register indexes of the averager and its
// bit-serial multiplier.
// ----------------------------------------------------------------------------
package rdra_pkg;

    // Multiplier operand and product widths.
    localparam int MUL_A_BITS   = 32;
    localparam int MUL_B_BITS   = 24;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_CNT_BITS = 5;

    // Field and register widths.
    localparam int COUNT_IN_BITS = 16;
    localparam int WORD_BITS     = 32;
    localparam int ALPHA_BITS    = 16;
    localparam int DOSE_BITS     = 24;
    localparam int ACC_BITS      = 48;
    localparam int EWMA_FRAC     = 10;
    localparam int RATE_CPM_BITS = WORD_BITS - EWMA_FRAC;
    localparam int DOSE_EWMA_SHIFT = 18;
    localparam int DOSE_CPM_SHIFT  = 8;

    // Window lengths and the fill counter that tracks how many seconds exist.
    localparam int FILL_BITS = 6;
    localparam logic [FILL_BITS-1:0] WIN_SHORT  = 6'd10;
    localparam logic [FILL_BITS-1:0] WIN_MEDIUM = 6'd30;
    localparam logic [FILL_BITS-1:0] WIN_LONG   = 6'd60;

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ALPHA_SHORT = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ALPHA_LONG  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DOSE_FACTOR = 2'd2;

    // Register reset values.
    localparam logic [ALPHA_BITS-1:0] ALPHA_SHORT_RST = 16'd6554;
    localparam logic [ALPHA_BITS-1:0] ALPHA_LONG_RST  = 16'd2185;
    localparam logic [DOSE_BITS-1:0]  DOSE_FACTOR_RST = 24'd95630;

    typedef logic [MUL_A_BITS-1:0] t_mul_a;
    typedef logic [MUL_B_BITS-1:0] t_mul_b;
    typedef logic [MUL_P_BITS-1:0] t_mul_p;
    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [DOSE_BITS-1:0]  t_cfg_data;

endpackage

>>> design/rdra_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle. The
// product is ready after the last multiplier bit has been retired and is flagged by o_done.
// ----------------------------------------------------------------------------
module rdra_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rdra_pkg::t_mul_a i_a,
    input  rdra_pkg::t_mul_b i_b,
    output logic            o_done,
    output rdra_pkg::t_mul_p o_product
);
    import rdra_pkg::*;

    t_mul_a                  r_a;
    logic [MUL_A_BITS-1:0]   r_hi;
    t_mul_b                  r_lo;
    logic [MUL_CNT_BITS-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic [MUL_A_BITS:0]     n_sum;

    // One partial product is added to the upper half per step.
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_BITS'(MUL_B_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Product shift register: low bits enter from the adder as the
    // multiplier bits leave.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_sum[MUL_A_BITS:1];
            r_lo <= {n_sum[0], r_lo[MUL_B_BITS-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

>>> design/radiation_dose_rate_averager_unit.sv
// ----------------------------------------------------------------------------
// Radiation dose-rate averager
// Keeps 10, 30 and 60 second window sums of per-second pulse counts, smooths
// the 10 s and 30 s rates and converts the averages and 60 s sum to dose rates.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Contents
//  s_axis    | in        | second_count, total_ticks, uptime_seconds
//  m_axis    | out       | total_ticks_out, dose_short, dose_medium, dose_long,
//            |           | uptime_out
//  i_cfg_*   | in        | alpha_short, alpha_long, dose_factor writes
//
// The seven products of an item run one after another through a single
// bit-serial multiplier that retires one bit per cycle. The three ring reads
// are issued one after another on the single read port. The input side takes
// the next item as soon as the block returns to idle, even while a result
// still waits in the output register; a stalled output holds the sequencer
// only at its last step. Reset clears the fill count rather than the ring, so
// entries not yet written read as zero and no clearing pass is needed.
// ----------------------------------------------------------------------------
module radiation_dose_rate_averager_unit #(
    parameter int RING_DEPTH = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [15:0] second_count, [47:16] total_ticks, [79:48] uptime_seconds
    input  logic [79:0]         s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [31:0] total_ticks_out, [63:32] dose_short, [95:64] dose_medium,
    // [127:96] dose_long, [159:128] uptime_out
    output logic [159:0]        m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [rdra_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  rdra_pkg::t_cfg_data i_cfg_wdata
);
    import rdra_pkg::*;

    localparam int HEAD_BITS = $clog2(RING_DEPTH);
    localparam int SUM_BITS  = COUNT_BITS + 6;
    localparam int CPM_W     = (SUM_BITS + 3 > RATE_CPM_BITS) ? SUM_BITS + 3
                                                              : RATE_CPM_BITS + 1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD10     = 4'd1;
    localparam logic [3:0] S_RD30     = 4'd2;
    localparam logic [3:0] S_RD60     = 4'd3;
    localparam logic [3:0] S_SUM      = 4'd4;
    localparam logic [3:0] S_RATE     = 4'd5;
    localparam logic [3:0] S_MUL_GO   = 4'd6;
    localparam logic [3:0] S_MUL_WAIT = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    // Multiplier operations in issue order.
    localparam logic [2:0] OP_RATE_S = 3'd0;
    localparam logic [2:0] OP_AVG_S  = 3'd1;
    localparam logic [2:0] OP_RATE_M = 3'd2;
    localparam logic [2:0] OP_AVG_M  = 3'd3;
    localparam logic [2:0] OP_DOSE_S = 3'd4;
    localparam logic [2:0] OP_DOSE_M = 3'd5;
    localparam logic [2:0] OP_DOSE_L = 3'd6;

    logic [3:0]            r_state;
    logic [2:0]            r_op;
    logic [HEAD_BITS-1:0]  r_head;
    logic [FILL_BITS-1:0]  r_fill;
    logic [SUM_BITS-1:0]   r_sum10;
    logic [SUM_BITS-1:0]   r_sum30;
    logic [SUM_BITS-1:0]   r_sum60;
    t_word                 r_ewma_s;
    t_word                 r_ewma_m;
    logic [ALPHA_BITS-1:0] r_alpha_s;
    logic [ALPHA_BITS-1:0] r_alpha_l;
    logic [DOSE_BITS-1:0]  r_dose;

    logic [COUNT_BITS-1:0] r_ring [RING_DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [HEAD_BITS-1:0]  n_rd_addr;

    logic [COUNT_BITS-1:0] r_count;
    t_word                 r_ticks;
    t_word                 r_uptime;
    logic [COUNT_BITS-1:0] r_old10;
    logic [COUNT_BITS-1:0] r_old30;
    t_word                 r_rate_s;
    t_word                 r_rate_m;
    t_word                 r_avg_s;
    t_word                 r_avg_m;
    logic [ACC_BITS-1:0]   r_acc;
    t_word                 r_dose_s;
    t_word                 r_dose_m;
    t_word                 r_dose_l;
    logic                  r_m_valid;
    logic [159:0]          r_m_data;

    logic [CPM_W-1:0]      n_cpm10;
    logic [CPM_W-1:0]      n_cpm30;
    t_word                 n_rate_s;
    t_word                 n_rate_m;
    logic [ACC_BITS-1:0]   n_acc_sum;
    logic [COUNT_BITS-1:0] n_old60;
    logic [HEAD_BITS-1:0]  n_head;

    t_mul_a                mul_a;
    t_mul_b                mul_b;
    logic                  mul_done;
    t_mul_p                mul_p;

    // Ring index k seconds older than h, modulo the ring depth.
    function automatic logic [HEAD_BITS-1:0] ring_back(
        input logic [HEAD_BITS-1:0] h,
        input logic [FILL_BITS-1:0] k
    );
        logic [HEAD_BITS:0] hx;
        logic [HEAD_BITS:0] kx;
        hx = {1'b0, h};
        kx = (HEAD_BITS + 1)'(k);
        if (hx >= kx) begin
            return HEAD_BITS'(hx - kx);
        end else begin
            return HEAD_BITS'(hx + (HEAD_BITS + 1)'(RING_DEPTH) - kx);
        end
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign n_head = (r_head == HEAD_BITS'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Read address of the entry leaving each window.
    always_comb begin
        case (r_state)
            S_RD10:  n_rd_addr = ring_back(r_head, WIN_SHORT);
            S_RD30:  n_rd_addr = ring_back(r_head, WIN_MEDIUM);
            S_RD60:  n_rd_addr = ring_back(r_head, WIN_LONG);
            default: n_rd_addr = r_head;
        endcase
    end

    // Count ring, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD60) begin
            r_ring[r_head] <= r_count;
        end
        r_rd_data <= r_ring[n_rd_addr];
    end

    // Seconds that predate the first item read as zero.
    assign n_old60 = (r_fill >= WIN_LONG) ? r_rd_data : '0;

    // Counts per minute and saturated Q22.10 rates.
    always_comb begin
        n_cpm10 = (CPM_W'(r_sum10) << 2) + (CPM_W'(r_sum10) << 1);
        n_cpm30 = CPM_W'(r_sum30) << 1;
        n_rate_s = (|n_cpm10[CPM_W-1:RATE_CPM_BITS]) ? '1
                 : {n_cpm10[RATE_CPM_BITS-1:0], {EWMA_FRAC{1'b0}}};
        n_rate_m = (|n_cpm30[CPM_W-1:RATE_CPM_BITS]) ? '1
                 : {n_cpm30[RATE_CPM_BITS-1:0], {EWMA_FRAC{1'b0}}};
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_op)
            OP_RATE_S: begin
                mul_a = r_rate_s;
                mul_b = MUL_B_BITS'(r_alpha_s);
            end
            OP_AVG_S: begin
                mul_a = r_avg_s;
                mul_b = MUL_B_BITS'(17'h10000 - {1'b0, r_alpha_s});
            end
            OP_RATE_M: begin
                mul_a = r_rate_m;
                mul_b = MUL_B_BITS'(r_alpha_l);
            end
            OP_AVG_M: begin
                mul_a = r_avg_m;
                mul_b = MUL_B_BITS'(17'h10000 - {1'b0, r_alpha_l});
            end
            OP_DOSE_S: begin
                mul_a = r_ewma_s;
                mul_b = r_dose;
            end
            OP_DOSE_M: begin
                mul_a = r_ewma_m;
                mul_b = r_dose;
            end
            default: begin
                mul_a = MUL_A_BITS'(r_sum60);
                mul_b = r_dose;
            end
        endcase
    end

    assign n_acc_sum = r_acc + mul_p[ACC_BITS-1:0];

    rdra_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_MUL_GO),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_s <= ALPHA_SHORT_RST;
            r_alpha_l <= ALPHA_LONG_RST;
            r_dose    <= DOSE_FACTOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ALPHA_SHORT: r_alpha_s <= i_cfg_wdata[ALPHA_BITS-1:0];
                REG_ALPHA_LONG:  r_alpha_l <= i_cfg_wdata[ALPHA_BITS-1:0];
                REG_DOSE_FACTOR: r_dose    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_RATE_S;
            r_head    <= '0;
            r_fill    <= '0;
            r_sum10   <= '0;
            r_sum30   <= '0;
            r_sum60   <= '0;
            r_ewma_s  <= '0;
            r_ewma_m  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // The result flag rises when a result is loaded and falls after
            // its transfer.
            if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_head <= n_head;
                        r_state <= S_RD10;
                    end
                end
                S_RD10:  r_state <= S_RD30;
                S_RD30:  r_state <= S_RD60;
                S_RD60:  r_state <= S_SUM;
                S_SUM: begin
                    r_sum10 <= r_sum10 + SUM_BITS'(r_count) - SUM_BITS'(r_old10);
                    r_sum30 <= r_sum30 + SUM_BITS'(r_count) - SUM_BITS'(r_old30);
                    r_sum60 <= r_sum60 + SUM_BITS'(r_count) - SUM_BITS'(n_old60);
                    if (r_fill != WIN_LONG) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_RATE;
                end
                S_RATE: begin
                    r_op    <= OP_RATE_S;
                    r_state <= S_MUL_GO;
                end
                S_MUL_GO: r_state <= S_MUL_WAIT;
                S_MUL_WAIT: begin
                    if (mul_done) begin
                        if (r_op == OP_AVG_S) begin
                            r_ewma_s <= n_acc_sum[ACC_BITS-1:ALPHA_BITS];
                        end
                        if (r_op == OP_AVG_M) begin
                            r_ewma_m <= n_acc_sum[ACC_BITS-1:ALPHA_BITS];
                        end
                        if (r_op == OP_DOSE_L) begin
                            r_state <= S_OUT;
                        end else begin
                            r_op    <= r_op + 1'b1;
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item payload, window leavers, rates and products.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_count  <= COUNT_BITS'(s_axis_tdata[COUNT_IN_BITS-1:0]);
            r_ticks  <= s_axis_tdata[47:16];
            r_uptime <= s_axis_tdata[79:48];
        end
        if (r_state == S_RD30) begin
            r_old10 <= (r_fill >= WIN_SHORT) ? r_rd_data : '0;
        end
        if (r_state == S_RD60) begin
            r_old30 <= (r_fill >= WIN_MEDIUM) ? r_rd_data : '0;
        end
        // An empty average starts from the current rate.
        if (r_state == S_RATE) begin
            r_rate_s <= n_rate_s;
            r_rate_m <= n_rate_m;
            r_avg_s  <= (r_ewma_s == '0 && n_rate_s != '0) ? n_rate_s : r_ewma_s;
            r_avg_m  <= (r_ewma_m == '0 && n_rate_m != '0) ? n_rate_m : r_ewma_m;
        end
        if (r_state == S_MUL_WAIT && mul_done) begin
            case (r_op)
                OP_RATE_S, OP_RATE_M: r_acc <= mul_p[ACC_BITS-1:0];
                OP_DOSE_S: r_dose_s <= (|mul_p[MUL_P_BITS-1:WORD_BITS+DOSE_EWMA_SHIFT])
                    ? '1 : mul_p[WORD_BITS+DOSE_EWMA_SHIFT-1:DOSE_EWMA_SHIFT];
                OP_DOSE_M: r_dose_m <= (|mul_p[MUL_P_BITS-1:WORD_BITS+DOSE_EWMA_SHIFT])
                    ? '1 : mul_p[WORD_BITS+DOSE_EWMA_SHIFT-1:DOSE_EWMA_SHIFT];
                OP_DOSE_L: r_dose_l <= (|mul_p[MUL_P_BITS-1:WORD_BITS+DOSE_CPM_SHIFT])
                    ? '1 : mul_p[WORD_BITS+DOSE_CPM_SHIFT-1:DOSE_CPM_SHIFT];
                default: ;
            endcase
        end
        // Result register, loaded once the previous result has left.
        if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
            r_m_data <= {r_uptime, r_dose_l, r_dose_m, r_dose_s, r_ticks};
        end
    end

endmodule
